### rtl/assert_macros.svh
// Assertion macros used by the CSV record tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// Check an implication whose consequent starts in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/csvtok_pkg.sv
// Types and constants of the CSV record tokenizer.
package csvtok_pkg;

	typedef enum logic [1:0] {
		BOM_WAIT = 2'd0,
		BOM_EF   = 2'd1,
		BOM_EFBB = 2'd2,
		BOM_DONE = 2'd3
	} bom_stage_t;

	typedef enum logic [1:0] {
		KIND_DATA       = 2'd0,
		KIND_FIELD_END  = 2'd1,
		KIND_RECORD_END = 2'd2,
		KIND_UNUSED     = 2'd3
	} token_kind_t;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam logic [7:0] BOM_B0   = 8'hEF;
	localparam logic [7:0] BOM_B1   = 8'hBB;
	localparam logic [7:0] BOM_B2   = 8'hBF;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int MAX_RESULTS = 3;

endpackage

### rtl/csv_record_tokenizer_unit.sv
// CSV record tokenizer: document bytes in, field and record tokens out.
//
// Input channel (in_valid/in_ready): action selects a document byte or the end
// of the document; byte_value carries the byte. Output channel
// (out_valid/out_ready): token_kind, data_byte and last, one token per
// transaction; last marks the final token caused by one input transaction.
// An input transaction is parsed in the cycle it is accepted and its tokens
// (zero to three) sit in a three-slot result register; the first token shows
// on the output in the cycle after acceptance.
// Throughput is one input transaction per cycle while each causes at most one
// token and the receiver is ready; an item causing several tokens holds the
// input while the single output port drains the slots. Items causing no token
// are taken at once when the slots are empty or draining their last token.
// A stalled receiver holds the current token; the input is refused until the
// slots are on their last token and it is being taken.
// Reset clears the byte-order-mark stage, the quote flags, the open-record
// flag and empties the result slots. End of document flushes an open record
// and returns the parser to its start state.
`include "assert_macros.svh"

module csv_record_tokenizer_unit
	import csvtok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] token_kind,
	output logic [7:0] data_byte,
	output logic       last
);

	bom_stage_t bom_q, bom_d;
	logic       quoted_q, quoted_d;
	logic       pend_q, pend_d;
	logic       open_q, open_d;

	logic [1:0] kind_s1 [MAX_RESULTS];
	logic [7:0] data_s1 [MAX_RESULTS];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	logic [1:0] new_kind [MAX_RESULTS];
	logic [7:0] new_data [MAX_RESULTS];
	logic [1:0] new_cnt;

	logic       in_fire;
	logic       out_fire;
	logic [1:0] idx_inc;

	// Parser combinational logic
	logic [1:0] rep_n;
	logic       do_parse;
	logic       do_plain;
	logic [7:0] pb;
	logic       tail_v;
	logic [1:0] tail_kind;
	logic [7:0] tail_data;

	assign idx_inc   = idx_q + 2'd1;
	assign out_valid = (idx_q != cnt_q);
	assign last      = (idx_inc == cnt_q);
	assign in_ready  = !out_valid || (out_ready && last);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign token_kind = kind_s1[idx_q];
	assign data_byte  = data_s1[idx_q];

	always_comb begin
		pb        = byte_value;
		rep_n     = 2'd0;
		do_parse  = 1'b0;
		do_plain  = 1'b0;
		tail_v    = 1'b0;
		tail_kind = KIND_DATA;
		tail_data = 8'h00;
		bom_d     = bom_q;
		quoted_d  = quoted_q;
		pend_d    = pend_q;
		open_d    = open_q;

		if (action == ACT_END) begin
			if (bom_q == BOM_EF || bom_q == BOM_EFBB) begin
				rep_n = bom_q;
			end
			if (rep_n != 2'd0 || open_q || quoted_q) begin
				tail_v    = 1'b1;
				tail_kind = KIND_RECORD_END;
			end
			bom_d    = BOM_WAIT;
			quoted_d = 1'b0;
			pend_d   = 1'b0;
			open_d   = 1'b0;
		end else begin
			unique case (bom_q)
				BOM_WAIT: begin
					if (pb == BOM_B0) begin
						bom_d = BOM_EF;
					end else begin
						bom_d    = BOM_DONE;
						do_parse = 1'b1;
					end
				end
				BOM_EF: begin
					if (pb == BOM_B1) begin
						bom_d = BOM_EFBB;
					end else begin
						rep_n    = 2'd1;
						bom_d    = BOM_DONE;
						do_parse = 1'b1;
					end
				end
				BOM_EFBB: begin
					bom_d = BOM_DONE;
					if (pb != BOM_B2) begin
						rep_n    = 2'd2;
						do_parse = 1'b1;
					end
				end
				BOM_DONE: begin
					do_parse = 1'b1;
				end
				default: begin
					do_parse = 1'b1;
				end
			endcase
			// replayed mark bytes are content and open the record
			if (rep_n != 2'd0) begin
				open_d = 1'b1;
			end
			if (do_parse) begin
				priority if (quoted_q && pend_q) begin
					pend_d = 1'b0;
					if (pb == CH_QUOTE) begin
						tail_v    = 1'b1;
						tail_data = CH_QUOTE;
					end else begin
						quoted_d = 1'b0;
						do_plain = 1'b1;
					end
				end else if (quoted_q && pb == CH_QUOTE) begin
					pend_d = 1'b1;
				end else if (quoted_q) begin
					tail_v    = 1'b1;
					tail_data = pb;
				end else begin
					do_plain = 1'b1;
				end
			end
			if (do_plain) begin
				priority if (pb == CH_QUOTE) begin
					quoted_d = 1'b1;
					open_d   = 1'b1;
				end else if (pb == CH_COMMA) begin
					open_d    = 1'b1;
					tail_v    = 1'b1;
					tail_kind = KIND_FIELD_END;
				end else if (pb == CH_LF) begin
					open_d    = 1'b0;
					tail_v    = 1'b1;
					tail_kind = KIND_RECORD_END;
				end else if (pb == CH_CR) begin
					// drop
				end else begin
					open_d    = 1'b1;
					tail_v    = 1'b1;
					tail_data = pb;
				end
			end
		end
	end

	// Pack replayed mark bytes first, then the tail token
	always_comb begin
		new_kind[0] = KIND_DATA;
		new_kind[1] = KIND_DATA;
		new_kind[2] = KIND_DATA;
		new_data[0] = BOM_B0;
		new_data[1] = BOM_B1;
		new_data[2] = 8'h00;
		new_kind[rep_n] = tail_kind;
		new_data[rep_n] = tail_data;
		new_cnt = rep_n + {1'b0, tail_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bom_q    <= BOM_WAIT;
			quoted_q <= 1'b0;
			pend_q   <= 1'b0;
			open_q   <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (in_fire) begin
				bom_q    <= bom_d;
				quoted_q <= quoted_d;
				pend_q   <= pend_d;
				open_q   <= open_d;
				cnt_q    <= new_cnt;
				idx_q    <= 2'd0;
			end else if (out_fire) begin
				idx_q <= idx_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				kind_s1[i] <= new_kind[i];
				data_s1[i] <= new_data[i];
			end
		end
	end

	`ASSERT_CLK(a_idx_le_cnt, clk, arst_n, idx_q <= cnt_q)
	`ASSERT_CLK(a_pend_in_quotes, clk, arst_n, !pend_q || quoted_q)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, $stable(idx_q) && $stable(cnt_q))
	`ASSERT_NEXT(a_end_resets, clk, arst_n, in_fire && action == ACT_END, bom_q == BOM_WAIT && !quoted_q && !pend_q && !open_q)

endmodule
